// ===== rtl/capability_handle_table_core_assert.svh =====
// Assertion macros used by the table RTL core.
`ifndef CAPABILITY_HANDLE_TABLE_CORE_ASSERT_SVH
`define CAPABILITY_HANDLE_TABLE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted
`define CHT_ASSERT(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset
`define CHT_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHT_ASSERT(label, clk, rstn, prop, msg)
`define CHT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/cht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cht_pkg;

	localparam int DATA_W       = 64;
	localparam int GEN_W        = 32;
	localparam int RIGHTS_W     = 4;
	localparam int REQ_RIGHTS_W = 8;
	localparam int STATUS_W     = 3;
	localparam int MODE_W       = 2;

	// stream widths: fields packed from bit 0, padded to whole bytes
	localparam int IN_TDATA_W   = 200;
	localparam int OUT_TDATA_W  = 200;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_CREATE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTRICT = 2'd2;
	localparam logic [MODE_W-1:0] MODE_REVOKE   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REVOKED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DENIED     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

	// one table entry
	typedef struct packed {
		logic                active;
		logic [GEN_W-1:0]    gen;
		logic [RIGHTS_W-1:0] rights;
		logic [DATA_W-1:0]   length;
		logic [DATA_W-1:0]   base;
	} cht_entry_t;

	// shared adder request and response
	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic              sub;
	} cht_alu_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] sum;
		logic              ovf;
	} cht_alu_rsp_t;

	// zero or any unknown bit set
	function automatic logic rights_bad(input logic [REQ_RIGHTS_W-1:0] r);
		return (r == '0) || (r[REQ_RIGHTS_W-1:RIGHTS_W] != '0);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/capability_handle_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Create and restrict, when their checks pass, end in a free-slot search that scans slots in
// order, 1..ENTRIES of them; lookup and revoke read the addressed slot once.
// One item at a time; the entry RAM, with one read and one write port, and the shared 64-bit adder set the rate.
// Reset (arst_n low, asynchronous) clears control; then a clearing pass
// writes every slot inactive with generation 1, and s_tready stays low until it ends.
`include "capability_handle_table_core_assert.svh"

module capability_handle_table_core import cht_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// handle[63:0], base_or_offset[127:64], region_length[191:128], rights[199:192]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  logic [MODE_W-1:0]      s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// status[2:0], new_handle[66:3], lookup_base[130:67], lookup_length[194:131],
	// lookup_rights[198:195], zero[199]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0]     LAST_IDX  = IW'(ENTRIES - 1);
	localparam logic [GEN_W-1:0]  ENTRIES_W = GEN_W'(ENTRIES);
	localparam logic [DATA_W-1:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

	// sequencer states
	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_CCHK = 4'd2;
	localparam logic [3:0] S_SRD  = 4'd3;
	localparam logic [3:0] S_SCHK = 4'd4;
	localparam logic [3:0] S_RCHK = 4'd5;
	localparam logic [3:0] S_FIND = 4'd6;
	localparam logic [3:0] S_FCHK = 4'd7;
	localparam logic [3:0] S_R1   = 4'd8;
	localparam logic [3:0] S_R2   = 4'd9;
	localparam logic [3:0] S_R3   = 4'd10;
	localparam logic [3:0] S_R4   = 4'd11;
	localparam logic [3:0] S_RVK  = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0]  state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic        m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// latched item and working registers
	logic [MODE_W-1:0]       mode_q;
	logic [DATA_W-1:0]       handle_q;
	logic [DATA_W-1:0]       bo_q;
	logic [DATA_W-1:0]       len_q;
	logic [REQ_RIGHTS_W-1:0] rights_q;
	logic [DATA_W-1:0]       cbase_q;
	logic [DATA_W-1:0]       diff_q;
	logic [STATUS_W-1:0]     status_q;
	logic [DATA_W-1:0]       nh_q;
	logic [DATA_W-1:0]       ob_q;
	logic [DATA_W-1:0]       ol_q;
	logic [RIGHTS_W-1:0]     orr_q;

	// entry RAM
	cht_entry_t    mem_q [ENTRIES];
	cht_entry_t    rdata_q;
	cht_entry_t    wr_data;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic          rd_en;
	logic [IW-1:0] rd_addr;

	cht_alu_req_t alu_req;
	cht_alu_rsp_t alu_rsp;

	logic [GEN_W-1:0] h_gen;
	logic [GEN_W-1:0] h_low;
	logic [GEN_W-1:0] slot_full;
	logic [IW-1:0]    slot;
	logic             handle_bad;
	logic             lk_rights_bad;
	logic             cchk_bad;
	logic             rchk_bad;
	logic             entry_live;
	logic             lk_denied;
	logic             rs_denied;
	logic [GEN_W-1:0] gen_new;
	logic             idx_last;
	logic             out_free;
	logic             accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign idx_last = (idx_q == LAST_IDX);

	// handle decode
	assign h_gen      = handle_q[DATA_W-1:GEN_W];
	assign h_low      = handle_q[GEN_W-1:0];
	assign slot_full  = h_low - 32'd1;
	assign slot       = slot_full[IW-1:0];
	assign handle_bad = (h_gen == '0) || (h_low == '0) || (h_low > ENTRIES_W);

	// item checks
	assign lk_rights_bad = (mode_q == MODE_LOOKUP) && (rights_q != '0) && rights_bad(rights_q);
	assign cchk_bad = (cbase_q == '0) || (len_q == '0) || ((cbase_q & PAGE_MASK) != '0) ||
		((len_q & PAGE_MASK) != '0) || alu_rsp.ovf || rights_bad(rights_q);
	assign rchk_bad = (len_q == '0) || ((bo_q & PAGE_MASK) != '0) ||
		((len_q & PAGE_MASK) != '0) || alu_rsp.ovf || rights_bad(rights_q);
	assign entry_live = rdata_q.active && (rdata_q.gen == h_gen);
	assign lk_denied  = (({4'd0, rdata_q.rights} & rights_q) != rights_q);
	assign rs_denied  = ((rights_q[RIGHTS_W-1:0] & ~rdata_q.rights) != '0);
	assign gen_new    = (rdata_q.gen == '0) ? 32'd1 : rdata_q.gen;

	// shared adder operand select
	always_comb begin
		alu_req = '0;
		case (state_q)
			S_CCHK: begin
				alu_req.a = cbase_q;
				alu_req.b = len_q;
			end
			S_RCHK: begin
				alu_req.a = bo_q;
				alu_req.b = len_q;
			end
			S_R1: begin
				alu_req.a   = rdata_q.length;
				alu_req.b   = bo_q;
				alu_req.sub = 1'b1;
			end
			S_R2: begin
				alu_req.a   = diff_q;
				alu_req.b   = len_q;
				alu_req.sub = 1'b1;
			end
			S_R3: begin
				alu_req.a = rdata_q.base;
				alu_req.b = rdata_q.length;
			end
			S_R4: begin
				alu_req.a = rdata_q.base;
				alu_req.b = bo_q;
			end
			S_RVK: begin
				alu_req.a = {32'd0, rdata_q.gen};
				alu_req.b = 64'd1;
			end
			default: begin
				alu_req.a = cbase_q;
				alu_req.b = len_q;
			end
		endcase
	end

	cht_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// RAM port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		case (state_q)
			S_INIT: begin
				wr_en       = 1'b1;
				wr_data.gen = 32'd1;
			end
			S_SCHK: begin
				wr_en          = !rdata_q.active;
				wr_data.active = 1'b1;
				wr_data.gen    = gen_new;
				wr_data.rights = rights_q[RIGHTS_W-1:0];
				wr_data.length = len_q;
				wr_data.base   = cbase_q;
			end
			S_RVK: begin
				wr_en       = 1'b1;
				wr_addr     = slot;
				wr_data.gen = alu_rsp.sum[GEN_W-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign rd_en   = (state_q == S_SRD) || (state_q == S_FIND);
	assign rd_addr = (state_q == S_SRD) ? idx_q : slot;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		case (state_q)
			S_INIT: begin
				idx_d = idx_q + IW'(1);
				if (idx_last) begin
					idx_d   = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						MODE_CREATE:   state_d = S_CCHK;
						MODE_RESTRICT: state_d = S_RCHK;
						default:       state_d = S_FIND;
					endcase
				end
			end
			S_CCHK: begin
				idx_d   = '0;
				state_d = cchk_bad ? S_DONE : S_SRD;
			end
			S_SRD: state_d = S_SCHK;
			S_SCHK: begin
				if (!rdata_q.active || idx_last) begin
					state_d = S_DONE;
				end else begin
					idx_d   = idx_q + IW'(1);
					state_d = S_SRD;
				end
			end
			S_RCHK: state_d = rchk_bad ? S_DONE : S_FIND;
			S_FIND: state_d = (lk_rights_bad || handle_bad) ? S_DONE : S_FCHK;
			S_FCHK: begin
				if (!entry_live) begin
					state_d = S_DONE;
				end else begin
					case (mode_q)
						MODE_RESTRICT: state_d = rs_denied ? S_DONE : S_R1;
						MODE_REVOKE:   state_d = S_RVK;
						default:       state_d = S_DONE;
					endcase
				end
			end
			S_R1: state_d = alu_rsp.ovf ? S_DONE : S_R2;
			S_R2: state_d = alu_rsp.ovf ? S_DONE : S_R3;
			S_R3: state_d = alu_rsp.ovf ? S_DONE : S_R4;
			S_R4: state_d = S_CCHK;
			S_RVK: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q   <= s_tuser;
					handle_q <= s_tdata[63:0];
					bo_q     <= s_tdata[127:64];
					cbase_q  <= s_tdata[127:64];
					len_q    <= s_tdata[191:128];
					rights_q <= s_tdata[199:192];
					status_q <= ST_OK;
					nh_q     <= '0;
					ob_q     <= '0;
					ol_q     <= '0;
					orr_q    <= '0;
				end
			end
			S_CCHK: begin
				if (cchk_bad) begin
					status_q <= ST_INVALID;
				end
			end
			S_SCHK: begin
				if (!rdata_q.active) begin
					nh_q <= {gen_new, {(GEN_W - IW){1'b0}}, idx_q} + 64'd1;
				end else if (idx_last) begin
					status_q <= ST_FULL;
				end
			end
			S_RCHK: begin
				if (rchk_bad) begin
					status_q <= ST_INVALID;
				end
			end
			S_FIND: begin
				if (lk_rights_bad) begin
					status_q <= ST_INVALID;
				end else if (handle_bad) begin
					status_q <= ST_BAD_HANDLE;
				end
			end
			S_FCHK: begin
				if (!entry_live) begin
					status_q <= ST_REVOKED;
				end else if (mode_q == MODE_LOOKUP) begin
					if (lk_denied) begin
						status_q <= ST_DENIED;
					end else begin
						ob_q  <= rdata_q.base;
						ol_q  <= rdata_q.length;
						orr_q <= rdata_q.rights;
					end
				end else if (mode_q == MODE_RESTRICT && rs_denied) begin
					status_q <= ST_DENIED;
				end
			end
			S_R1: begin
				// offset past source length
				if (alu_rsp.ovf) begin
					status_q <= ST_DENIED;
				end
				diff_q <= alu_rsp.sum;
			end
			S_R2: begin
				// sub-range longer than what remains
				if (alu_rsp.ovf) begin
					status_q <= ST_DENIED;
				end
			end
			S_R3: begin
				// source end wraps
				if (alu_rsp.ovf) begin
					status_q <= ST_INVALID;
				end
			end
			S_R4: begin
				cbase_q <= alu_rsp.sum;
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= {1'b0, orr_q, ol_q, ob_q, nh_q, status_q};
				end
			end
			default: begin
			end
		endcase
	end

	`CHT_ASSERT_ALWAYS(a_no_accept_in_reset, clk, !arst_n |-> (s_tready !== 1'b1), "item taken during reset")
	`CHT_ASSERT(a_one_item, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready, "second item overlaps")
	`CHT_ASSERT(a_no_write_idle, clk, arst_n, wr_en |-> !s_tready, "table written while idle")
	`CHT_ASSERT(a_fail_no_handle, clk, arst_n, (m_tvalid && (m_tdata[2:0] != ST_OK)) |-> (m_tdata[66:3] == 64'd0), "handle on failed item")

endmodule

`default_nettype wire

// ===== rtl/cht_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 64-bit add / subtract with wrap flag (carry out on add, borrow on subtract)
module cht_alu import cht_pkg::*; (
	input  cht_alu_req_t req,
	output cht_alu_rsp_t rsp
);

	logic [DATA_W:0] sum_w;
	logic [DATA_W-1:0] b_w;

	assign b_w   = req.sub ? ~req.b : req.b;
	assign sum_w = {1'b0, req.a} + {1'b0, b_w} + {{DATA_W{1'b0}}, req.sub};

	always_comb begin
		rsp.sum = sum_w[DATA_W-1:0];
		rsp.ovf = req.sub ? ~sum_w[DATA_W] : sum_w[DATA_W];
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import cht_pkg::*;

	localparam int ENTRY_COUNT = 16;
	localparam int PAGE_BITS = 12;
	localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_BITS) - 64'd1;
	localparam int RANDOM_ITEMS = 500;
	localparam int WATCHDOG_LIMIT = 2000;
	// restrict with a full free-slot scan is the slowest item
	localparam int DRAIN_CYCLES = 60;

	// one expected result item
	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] new_handle;
		logic [63:0] base;
		logic [63:0] length;
		logic [3:0]  rights;
	} table_result_t;

	// Mirror of the capability table; predicts one result per accepted item
	class cap_table_checker;
		logic [63:0] base_tab [ENTRY_COUNT];
		logic [63:0] length_tab [ENTRY_COUNT];
		logic [3:0] rights_tab [ENTRY_COUNT];
		logic [31:0] gen_tab [ENTRY_COUNT];
		bit live [ENTRY_COUNT];
		table_result_t pending_results [$];
		int errors;

		function new();
			errors = 0;
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				base_tab[i] = '0;
				length_tab[i] = '0;
				rights_tab[i] = '0;
				gen_tab[i] = 32'd1;
				live[i] = 1'b0;
			end
		endfunction

		// zero, or a bit above the four known rights
		function bit rights_malformed(logic [7:0] r);
			return (r == 8'd0) || (r[7:4] != 4'd0);
		endfunction

		function logic [2:0] find_live(logic [63:0] h, output int slot);
			logic [31:0] g;
			logic [31:0] low;
			g = h[63:32];
			low = h[31:0];
			slot = 0;
			if (g == 32'd0 || low == 32'd0) return ST_BAD_HANDLE;
			if (low - 32'd1 >= 32'(ENTRY_COUNT)) return ST_BAD_HANDLE;
			slot = int'(low - 32'd1);
			if (!live[slot] || gen_tab[slot] != g) return ST_REVOKED;
			return ST_OK;
		endfunction

		// range checks, then the first inactive slot takes the region
		function logic [2:0] claim_slot(logic [63:0] b, logic [63:0] len, logic [7:0] r,
				output logic [63:0] nh);
			nh = '0;
			if (b == '0 || len == '0 || (b & PAGE_MASK) != '0 || (len & PAGE_MASK) != '0 ||
					b > ~len || rights_malformed(r))
				return ST_INVALID;
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				if (!live[i]) begin
					if (gen_tab[i] == 32'd0) gen_tab[i] = 32'd1;
					base_tab[i] = b;
					length_tab[i] = len;
					rights_tab[i] = r[3:0];
					live[i] = 1'b1;
					nh = {gen_tab[i], 32'(i + 1)};
					return ST_OK;
				end
			end
			return ST_FULL;
		endfunction

		function void note_input(logic [1:0] op, logic [63:0] h, logic [63:0] bo,
				logic [63:0] len, logic [7:0] r);
			table_result_t res;
			logic [63:0] nh;
			logic [63:0] src_base;
			logic [63:0] src_len;
			logic [63:0] nb;
			logic [63:0] src_end;
			int slot;
			res = '0;
			nh = '0;
			case (op)
			MODE_CREATE: begin
				res.status = claim_slot(bo, len, r, nh);
			end
			MODE_LOOKUP: begin
				if (r != 8'd0 && rights_malformed(r)) begin
					res.status = ST_INVALID;
				end else begin
					res.status = find_live(h, slot);
					if (res.status == ST_OK) begin
						if (({4'd0, rights_tab[slot]} & r) != r) begin
							res.status = ST_DENIED;
						end else begin
							res.base = base_tab[slot];
							res.length = length_tab[slot];
							res.rights = rights_tab[slot];
						end
					end
				end
			end
			MODE_RESTRICT: begin
				// input checks come before the handle check
				if (len == '0 || (bo & PAGE_MASK) != '0 || (len & PAGE_MASK) != '0 ||
						bo > ~len || rights_malformed(r)) begin
					res.status = ST_INVALID;
				end else begin
					res.status = find_live(h, slot);
					if (res.status == ST_OK) begin
						src_base = base_tab[slot];
						src_len = length_tab[slot];
						if ((r[3:0] & ~rights_tab[slot]) != 4'd0 || bo > src_len ||
								len > src_len - bo) begin
							res.status = ST_DENIED;
						end else begin
							nb = src_base + bo;
							src_end = src_base + src_len;
							if (nb < src_base || src_end < src_base || nb > src_end ||
									len > src_end - nb)
								res.status = ST_INVALID;
							else
								res.status = claim_slot(nb, len, r, nh);
						end
					end
				end
			end
			default: begin
				res.status = find_live(h, slot);
				if (res.status == ST_OK) begin
					live[slot] = 1'b0;
					base_tab[slot] = '0;
					length_tab[slot] = '0;
					rights_tab[slot] = '0;
					gen_tab[slot] = gen_tab[slot] + 32'd1;
				end
			end
			endcase
			res.new_handle = (res.status == ST_OK) ? nh : 64'd0;
			pending_results.push_back(res);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [OUT_TDATA_W-1:0] d);
			table_result_t got;
			table_result_t want;
			got.status = d[2:0];
			got.new_handle = d[66:3];
			got.base = d[130:67];
			got.length = d[194:131];
			got.rights = d[198:195];
			if (pending_results.size() == 0) begin
				report($sformatf("result with none expected, status %0d", got.status));
				return;
			end
			want = pending_results.pop_front();
			if (got.status != want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.new_handle != want.new_handle)
				report($sformatf("new_handle %h, want %h", got.new_handle, want.new_handle));
			if (got.base != want.base)
				report($sformatf("lookup_base %h, want %h", got.base, want.base));
			if (got.length != want.length)
				report($sformatf("lookup_length %h, want %h", got.length, want.length));
			if (got.rights != want.rights)
				report($sformatf("lookup_rights %h, want %h", got.rights, want.rights));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [MODE_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	cap_table_checker table_chk = new();
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	int stall_style = 0;

	capability_handle_table_core #(
		.ENTRIES(ENTRY_COUNT),
		.PAGE_SHIFT(PAGE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: segments of always ready, coin flip, mostly stalled, alternating
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style <= $urandom_range(0, 3);
			stall_left <= $urandom_range(5, 60);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
		0: m_tready <= 1'b1;
		1: m_tready <= 1'($urandom);
		2: m_tready <= ($urandom_range(0, 3) == 0);
		default: m_tready <= ~m_tready;
		endcase
	end

	// result check
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready)
			table_chk.check_result(m_tdata);
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// sender bursts with random gaps
	task pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task send_item(input logic [1:0] op, input logic [63:0] h, input logic [63:0] bo,
			input logic [63:0] len, input logic [7:0] r);
		pace_sender();
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {r, len, bo, h};
		do @(posedge clk); while (!s_tready);
		table_chk.note_input(op, h, bo, len, r);
	endtask

	function automatic int pick_live();
		int n;
		int choice;
		n = 0;
		for (int i = 0; i < ENTRY_COUNT; i++)
			if (table_chk.live[i]) n++;
		if (n == 0) return -1;
		choice = $urandom_range(0, n - 1);
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			if (table_chk.live[i]) begin
				if (choice == 0) return i;
				choice--;
			end
		end
		return -1;
	endfunction

	// a handle one generation behind the current one, aimed at a randomly chosen slot
	function automatic logic [63:0] stale_handle();
		int s;
		s = $urandom_range(0, ENTRY_COUNT - 1);
		return {table_chk.gen_tab[s] - 32'd1, 32'(s + 1)};
	endfunction

	function automatic logic [63:0] live_handle(int slot);
		return {table_chk.gen_tab[slot], 32'(slot + 1)};
	endfunction

	// mostly well-formed requests on live handles, some stale handles and noise
	task random_request(output logic [1:0] op, output logic [63:0] h, output logic [63:0] bo,
			output logic [63:0] len, output logic [7:0] r);
		int pick;
		int slot;
		int pages;
		int off_pages;
		pick = $urandom_range(0, 99);
		slot = pick_live();
		op = 2'($urandom);
		h = {$urandom, $urandom};
		bo = {$urandom, $urandom};
		len = {$urandom, $urandom};
		r = 8'($urandom);
		if (pick < 10)
			return;
		if (slot < 0 || pick < 45) begin
			op = MODE_CREATE;
			bo = {$urandom, $urandom} & ~PAGE_MASK;
			len = 64'($urandom_range(1, 16)) << PAGE_BITS;
			if ($urandom_range(0, 19) != 0) r = 8'($urandom_range(1, 15));
		end else if (pick < 65) begin
			op = MODE_LOOKUP;
			h = ($urandom_range(0, 9) == 0) ? stale_handle() : live_handle(slot);
			if ($urandom_range(0, 19) != 0) r = 8'($urandom_range(0, 15));
		end else if (pick < 80) begin
			op = MODE_RESTRICT;
			pages = int'(table_chk.length_tab[slot] >> PAGE_BITS);
			off_pages = $urandom_range(0, pages - 1);
			bo = 64'(off_pages) << PAGE_BITS;
			len = 64'($urandom_range(1, pages - off_pages)) << PAGE_BITS;
			r = {4'd0, table_chk.rights_tab[slot] & 4'($urandom)};
			if (r == 8'd0) r = {4'd0, table_chk.rights_tab[slot]};
			h = live_handle(slot);
			// broken variants: overrun, extra right, stale source
			case ($urandom_range(0, 9))
			0: len = len + (64'd1 << PAGE_BITS);
			1: r = r | 8'($urandom_range(1, 15));
			2: h = stale_handle();
			default: ;
			endcase
		end else begin
			op = MODE_REVOKE;
			h = ($urandom_range(0, 9) == 0) ? stale_handle() : live_handle(slot);
		end
	endtask

	// edge cases right after reset; handles follow from the reset table
	task run_directed();
		send_item(MODE_LOOKUP, {32'd1, 32'd1}, 64'd0, 64'd0, 8'h00);
		send_item(MODE_LOOKUP, {32'd0, 32'd1}, 64'd0, 64'd0, 8'h01);
		send_item(MODE_LOOKUP, {32'd1, 32'd0}, 64'd0, 64'd0, 8'h01);
		send_item(MODE_REVOKE, {32'd1, 32'd17}, 64'd0, 64'd0, 8'h00);
		send_item(MODE_REVOKE, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 8'hFF);
		// create range and rights checks
		send_item(MODE_CREATE, 64'd0, 64'd0, 64'h1000, 8'h01);
		send_item(MODE_CREATE, 64'd0, 64'h1000, 64'd0, 8'h01);
		send_item(MODE_CREATE, 64'd0, 64'h1001, 64'h1000, 8'h01);
		send_item(MODE_CREATE, 64'd0, 64'h1000, 64'h0800, 8'h01);
		send_item(MODE_CREATE, 64'd0, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 8'h01);
		send_item(MODE_CREATE, 64'd0, 64'h2000, 64'h1000, 8'h00);
		send_item(MODE_CREATE, 64'd0, 64'h2000, 64'h1000, 8'h10);
		send_item(MODE_CREATE, 64'd0, 64'hFFFF_FFFF_FFFF_E000, 64'h1000, 8'h0F);
		send_item(MODE_CREATE, 64'd0, 64'h10000, 64'h8000, 8'h03);
		// lookups: no required rights, unknown right, missing right, top of memory
		send_item(MODE_LOOKUP, {32'd1, 32'd2}, 64'd0, 64'd0, 8'h00);
		send_item(MODE_LOOKUP, {32'd1, 32'd2}, 64'd0, 64'd0, 8'h80);
		send_item(MODE_LOOKUP, {32'd1, 32'd2}, 64'd0, 64'd0, 8'h04);
		send_item(MODE_LOOKUP, {32'd1, 32'd1}, 64'd0, 64'd0, 8'h0F);
		// restrict: fits, past the end, rights not a subset, bad extents
		send_item(MODE_RESTRICT, {32'd1, 32'd2}, 64'h1000, 64'h2000, 8'h01);
		send_item(MODE_RESTRICT, {32'd1, 32'd2}, 64'h6000, 64'h4000, 8'h01);
		send_item(MODE_RESTRICT, {32'd1, 32'd2}, 64'h0000, 64'h1000, 8'h08);
		send_item(MODE_RESTRICT, {32'd0, 32'd0}, 64'h0000, 64'd0, 8'h01);
		send_item(MODE_RESTRICT, {32'd1, 32'd2}, 64'h0010, 64'h1000, 8'h01);
		// revoke, then use the dead handle
		send_item(MODE_REVOKE, {32'd1, 32'd2}, 64'd0, 64'd0, 8'h00);
		send_item(MODE_LOOKUP, {32'd1, 32'd2}, 64'd0, 64'd0, 8'h00);
		send_item(MODE_RESTRICT, {32'd1, 32'd2}, 64'h0000, 64'h1000, 8'h01);
	endtask

	initial begin
		logic [1:0] op;
		logic [63:0] h;
		logic [63:0] bo;
		logic [63:0] len;
		logic [7:0] r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			random_request(op, h, bo, len, r);
			send_item(op, h, bo, len, r);
		end
		s_tvalid <= 1'b0;
		while (table_chk.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (table_chk.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cht_pkg.sv
rtl/cht_alu.sv
rtl/capability_handle_table_core.sv
tb/tb_top.sv
